// ===== hw/rtl/ball_direction_frame_decoder_assert.svh =====
// Assertion macros for the ball direction frame decoder.
`ifndef BALL_DIRECTION_FRAME_DECODER_ASSERT_SVH
`define BALL_DIRECTION_FRAME_DECODER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BDFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdfd assertion failed");

// Check that cons holds in the cycle after ante.
`define BDFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdfd assertion failed");

`endif

// ===== hw/rtl/bdfd_pkg.sv =====
// Types, constants and vector table for the ball direction frame decoder.
package bdfd_pkg;

  typedef enum logic [1:0] {
    StatusBall     = 2'd0,
    StatusNoBall   = 2'd1,
    StatusBadFrame = 2'd2
  } status_e;

  typedef struct packed {
    logic        end_ok;
    logic [15:0] angle;
    logic [15:0] distance;
  } frame_t;

  localparam logic [7:0]  StartByte = 8'hCC;
  localparam logic [7:0]  EndByte   = 8'hEE;
  localparam logic [15:0] NoBall    = 16'hFFFF;

  // floor(a / 360) == (a * AngRecip) >> AngRecipShift for any 16-bit a
  localparam logic [31:0] AngRecip      = 32'd46604;
  localparam int unsigned AngRecipShift = 24;

  localparam logic [8:0] Deg90  = 9'd90;
  localparam logic [8:0] Deg180 = 9'd180;
  localparam logic [8:0] Deg270 = 9'd270;
  localparam logic [8:0] Deg360 = 9'd360;

  localparam int unsigned CosStepCount = 10;
  localparam logic [6:0] CosSteps [CosStepCount] = '{
    7'd18, 7'd31, 7'd41, 7'd49, 7'd56, 7'd63, 7'd69, 7'd75, 7'd81, 7'd87
  };

  function automatic logic signed [4:0] quarter_cos10(logic [6:0] d);
    logic signed [4:0] v;
    v = 5'sd10;
    for (int i = 0; i < CosStepCount; i++) begin
      if (d > CosSteps[i]) begin
        v = v - 5'sd1;
      end
    end
    return v;
  endfunction

  function automatic logic signed [4:0] cos10(logic [8:0] a);
    logic [8:0]        d;
    logic              neg;
    logic signed [4:0] v;
    if (a <= Deg90) begin
      d   = a;
      neg = 1'b0;
    end else if (a <= Deg180) begin
      d   = Deg180 - a;
      neg = 1'b1;
    end else if (a <= Deg270) begin
      d   = a - Deg180;
      neg = 1'b1;
    end else begin
      d   = Deg360 - a;
      neg = 1'b0;
    end
    v = quarter_cos10(d[6:0]);
    return neg ? -v : v;
  endfunction

endpackage

// ===== hw/rtl/ball_direction_frame_decoder.sv =====
// Top level of the ball direction frame decoder.
// Takes one received byte per cycle while in_stall_o is low, with no gaps
// between frames. A frame is CC, angle (2 bytes, little endian), distance
// (2 bytes, little endian), EE; each completed frame gives one result
// through a three-stage pipeline (angle divide by reciprocal multiply, mod 360
// remainder, cosine table lookup). The angle and distance words sit in a
// two-entry memory with registered reads. Output stall backs up through the
// pipeline and holds the input only when all three stages are full.
module ball_direction_frame_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [15:0]       angle_o,
  output logic [15:0]       distance_o,
  output logic signed [4:0] velocity_x_o,
  output logic signed [4:0] velocity_y_o
);

`include "ball_direction_frame_decoder_assert.svh"

  logic              beat;
  logic              pipe_ready;
  logic              frame_valid;
  bdfd_pkg::frame_t  frame;
  bdfd_pkg::status_e status;

  assign in_stall_o = !pipe_ready;
  assign beat       = in_valid_i && pipe_ready;

  bdfd_frame_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  bdfd_vector_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .ready_o       (pipe_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .angle_o       (angle_o),
    .distance_o    (distance_o),
    .velocity_x_o  (velocity_x_o),
    .velocity_y_o  (velocity_y_o)
  );

  assign status_o = status;

  `BDFD_ASSERT_NEXT(a_frame_then_hunt, frame_valid, !frame_valid)
  `BDFD_ASSERT_IMP(a_bad_frame_zero,
      out_valid_o && status == bdfd_pkg::StatusBadFrame,
      angle_o == '0 && distance_o == '0)
  `BDFD_ASSERT_IMP(a_stop_zero_vector,
      out_valid_o && status != bdfd_pkg::StatusBall,
      velocity_x_o == '0 && velocity_y_o == '0)
  `BDFD_ASSERT_IMP(a_ball_no_sentinel,
      out_valid_o && status == bdfd_pkg::StatusBall,
      angle_o != bdfd_pkg::NoBall && distance_o != bdfd_pkg::NoBall)

endmodule

// ===== hw/rtl/bdfd_frame_store.sv =====
// Frame hunter with the field word memory.
module bdfd_frame_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       rx_byte_i,
  output logic             frame_valid_o,
  output bdfd_pkg::frame_t frame_o
);

  typedef enum logic [2:0] {
    PosHunt   = 3'd0,
    PosAngLo  = 3'd1,
    PosAngHi  = 3'd2,
    PosDistLo = 3'd3,
    PosDistHi = 3'd4,
    PosEnd    = 3'd5
  } pos_e;

  localparam logic AddrAngle = 1'b0;
  localparam logic AddrDist  = 1'b1;

  pos_e        pos_q, pos_d;
  logic [7:0]  lo_q, lo_d;
  logic [15:0] mem_q [2];
  logic        wr_en;
  logic        wr_addr;
  logic [15:0] wr_data;
  logic        rd_en;
  logic [15:0] rd_ang_q;
  logic [15:0] rd_dist_q;

  always_comb begin
    pos_d   = pos_q;
    lo_d    = lo_q;
    wr_en   = 1'b0;
    wr_addr = AddrAngle;
    wr_data = {rx_byte_i, lo_q};
    rd_en   = 1'b0;
    if (beat_i) begin
      unique case (pos_q)
        PosHunt: begin
          if (rx_byte_i == bdfd_pkg::StartByte) begin
            pos_d = PosAngLo;
          end
        end
        PosAngLo: begin
          lo_d  = rx_byte_i;
          pos_d = PosAngHi;
        end
        PosAngHi: begin
          wr_en   = 1'b1;
          wr_addr = AddrAngle;
          pos_d   = PosDistLo;
        end
        PosDistLo: begin
          lo_d  = rx_byte_i;
          pos_d = PosDistHi;
        end
        PosDistHi: begin
          wr_en   = 1'b1;
          wr_addr = AddrDist;
          rd_en   = 1'b1;
          pos_d   = PosEnd;
        end
        PosEnd: begin
          pos_d = PosHunt;
        end
        default: begin
          pos_d = PosHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      lo_q  <= '0;
    end else begin
      pos_q <= pos_d;
      lo_q  <= lo_d;
    end
  end

  // forward the distance word written in the same cycle as the read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_ang_q  <= mem_q[AddrAngle];
      rd_dist_q <= (wr_en && wr_addr == AddrDist) ? wr_data : mem_q[AddrDist];
    end
  end

  assign frame_valid_o    = beat_i && (pos_q == PosEnd);
  assign frame_o.end_ok   = (rx_byte_i == bdfd_pkg::EndByte);
  assign frame_o.angle    = rd_ang_q;
  assign frame_o.distance = rd_dist_q;

endmodule

// ===== hw/rtl/bdfd_vector_pipe.sv =====
// Status, angle reduction and drive vector pipeline.
module bdfd_vector_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 frame_valid_i,
  input  bdfd_pkg::frame_t     frame_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bdfd_pkg::status_e    status_o,
  output logic [15:0]          angle_o,
  output logic [15:0]          distance_o,
  output logic signed [4:0]    velocity_x_o,
  output logic signed [4:0]    velocity_y_o
);

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  bdfd_pkg::status_e st1_q, st2_q, st3_q, st1_d;
  logic [15:0]       ang1_q, ang2_q, ang3_q, ang1_d;
  logic [15:0]       dist1_q, dist2_q, dist3_q, dist1_d;
  logic [7:0]        q1_q;
  logic [31:0]       prod;
  logic [16:0]       qx;
  logic [15:0]       diff;
  logic [8:0]        r2_q;
  logic [8:0]        r_sin;
  logic signed [4:0] vx3_q, vy3_q;

  assign rdy3    = !v3_q || !out_stall_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    if (!frame_i.end_ok) begin
      st1_d   = bdfd_pkg::StatusBadFrame;
      ang1_d  = '0;
      dist1_d = '0;
    end else begin
      ang1_d  = frame_i.angle;
      dist1_d = frame_i.distance;
      if (frame_i.angle == bdfd_pkg::NoBall || frame_i.distance == bdfd_pkg::NoBall) begin
        st1_d = bdfd_pkg::StatusNoBall;
      end else begin
        st1_d = bdfd_pkg::StatusBall;
      end
    end
  end

  assign prod  = 32'(ang1_d) * bdfd_pkg::AngRecip;
  assign qx    = 17'(q1_q) * 17'(bdfd_pkg::Deg360);
  assign diff  = ang1_q - qx[15:0];
  assign r_sin = (r2_q >= bdfd_pkg::Deg90) ? (r2_q - bdfd_pkg::Deg90)
                                           : (r2_q + bdfd_pkg::Deg270);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= frame_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && frame_valid_i) begin
      st1_q   <= st1_d;
      ang1_q  <= ang1_d;
      dist1_q <= dist1_d;
      q1_q    <= prod[bdfd_pkg::AngRecipShift +: 8];
    end
    if (rdy2 && v1_q) begin
      st2_q   <= st1_q;
      ang2_q  <= ang1_q;
      dist2_q <= dist1_q;
      r2_q    <= diff[8:0];
    end
    if (rdy3 && v2_q) begin
      st3_q   <= st2_q;
      ang3_q  <= ang2_q;
      dist3_q <= dist2_q;
      if (st2_q == bdfd_pkg::StatusBall) begin
        vx3_q <= bdfd_pkg::cos10(r2_q);
        vy3_q <= bdfd_pkg::cos10(r_sin);
      end else begin
        vx3_q <= '0;
        vy3_q <= '0;
      end
    end
  end

  assign out_valid_o  = v3_q;
  assign status_o     = st3_q;
  assign angle_o      = ang3_q;
  assign distance_o   = dist3_q;
  assign velocity_x_o = vx3_q;
  assign velocity_y_o = vy3_q;

endmodule

// ===== tb/tb_ball_direction_frame_decoder.sv =====
// Self-checking testbench for the ball direction frame decoder.
module tb_ball_direction_frame_decoder;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CosKnees[10] = '{18, 31, 41, 49, 56, 63, 69, 75, 81, 87};
  localparam int unsigned SpecialAngles[16] = '{
    0, 1, 18, 19, 45, 90, 91, 135, 180, 225, 270, 271, 359, 360, 720, 65534
  };

  typedef struct packed {
    bdfd_pkg::status_e status;
    logic [15:0]       angle;
    logic [15:0]       distance;
    logic signed [4:0] vel_x;
    logic signed [4:0] vel_y;
  } drive_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [15:0]       angle_o;
  logic [15:0]       distance_o;
  logic signed [4:0] velocity_x_o;
  logic signed [4:0] velocity_y_o;

  drive_result_t pending_results[$];
  logic [2:0]    frame_pos;
  logic [31:0]   frame_payload;
  bit            gaps_on;
  int unsigned   cycle_count;
  int unsigned   bytes_sent;
  int unsigned   mismatch_count;
  int unsigned   ball_count;
  int unsigned   no_ball_count;
  int unsigned   bad_frame_count;

  ball_direction_frame_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .angle_o      (angle_o),
    .distance_o   (distance_o),
    .velocity_x_o (velocity_x_o),
    .velocity_y_o (velocity_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [4:0] round_cos10(int unsigned deg);
    int unsigned fold;
    int          steps;
    logic        flip;
    flip = (deg > 90) && (deg <= 270);
    if (deg <= 90) begin
      fold = deg;
    end else if (deg <= 180) begin
      fold = 180 - deg;
    end else if (deg <= 270) begin
      fold = deg - 180;
    end else begin
      fold = 360 - deg;
    end
    steps = 10;
    foreach (CosKnees[i]) begin
      if (fold > CosKnees[i]) begin
        steps--;
      end
    end
    return 5'(flip ? -steps : steps);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    drive_result_t r;
    int unsigned   a;
    if (frame_pos == 3'd0 || frame_pos > 3'd5) begin
      frame_pos = (b == bdfd_pkg::StartByte) ? 3'd1 : 3'd0;
    end else if (frame_pos <= 3'd4) begin
      frame_payload = {b, frame_payload[31:8]};
      frame_pos = frame_pos + 3'd1;
    end else begin
      frame_pos = 3'd0;
      r = '0;
      r.status = bdfd_pkg::StatusBadFrame;
      if (b == bdfd_pkg::EndByte) begin
        r.angle = frame_payload[15:0];
        r.distance = frame_payload[31:16];
        if (r.angle == bdfd_pkg::NoBall || r.distance == bdfd_pkg::NoBall) begin
          r.status = bdfd_pkg::StatusNoBall;
        end else begin
          a = r.angle % 360;
          r.status = bdfd_pkg::StatusBall;
          r.vel_x = round_cos10(a);
          r.vel_y = round_cos10((a + 270) % 360);
        end
      end
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, drive_result_t e);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): expected status %0d angle %0d distance %0d vel %0d,%0d",
               what, e.status, e.angle, e.distance, e.vel_x, e.vel_y);
      $display("                got status %0d angle %0d distance %0d vel %0d,%0d",
               status_o, angle_o, distance_o, velocity_x_o, velocity_y_o);
    end
  endtask

  always @(posedge clk_i) begin
    drive_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("no result pending", '0);
      end else begin
        e = pending_results.pop_front();
        if (status_o != e.status || angle_o != e.angle || distance_o != e.distance ||
            velocity_x_o != e.vel_x || velocity_y_o != e.vel_y) begin
          report_mismatch("field", e);
        end else begin
          case (e.status)
            bdfd_pkg::StatusBall:   ball_count++;
            bdfd_pkg::StatusNoBall: no_ball_count++;
            default:                bad_frame_count++;
          endcase
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(logic [15:0] angle, logic [15:0] distance, logic [7:0] end_b);
    send_byte(bdfd_pkg::StartByte);
    send_byte(angle[7:0]);
    send_byte(angle[15:8]);
    send_byte(distance[7:0]);
    send_byte(distance[15:8]);
    send_byte(end_b);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0:       return 16'(SpecialAngles[$urandom_range(0, 15)]);
      1, 2:    return 16'($urandom_range(0, 359));
      3:       return 16'($urandom_range(360, 65534));
      4:       return bdfd_pkg::NoBall;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 9))
      0:       return bdfd_pkg::NoBall;
      1:       return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(bdfd_pkg::EndByte);
  endtask

  task automatic test_field_extremes();
    send_frame(16'd0, 16'd0, bdfd_pkg::EndByte);
    send_frame(16'hFFFE, 16'hFFFE, bdfd_pkg::EndByte);
  endtask

  task automatic test_no_ball();
    send_frame(bdfd_pkg::NoBall, 16'd100, bdfd_pkg::EndByte);
    send_frame(16'd45, bdfd_pkg::NoBall, bdfd_pkg::EndByte);
  endtask

  task automatic test_start_inside_frame();
    send_frame(16'hCCCC, 16'h00CC, bdfd_pkg::StartByte);
  endtask

  task automatic test_random_frames(int unsigned byte_goal);
    logic [7:0] end_b;
    while (bytes_sent < byte_goal) begin
      case ($urandom_range(0, 9))
        8: begin
          do end_b = 8'($urandom); while (end_b == bdfd_pkg::EndByte);
          send_frame(pick_angle(), pick_distance(), end_b);
        end
        9: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
        default: begin
          send_frame(pick_angle(), pick_distance(), bdfd_pkg::EndByte);
        end
      endcase
    end
  endtask

  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_steady_stream(int unsigned byte_goal);
    gaps_on = 1'b0;
    while (bytes_sent < byte_goal) begin
      send_frame(pick_angle(), pick_distance(), bdfd_pkg::EndByte);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = 8'h00;
    frame_pos     = 3'd0;
    frame_payload = 32'd0;
    gaps_on       = 1'b1;
    cycle_count   = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_hunting();
    test_field_extremes();
    test_no_ball();
    test_start_inside_frame();
    test_random_frames(260);
    test_drain_pause();
    test_random_frames(460);
    test_steady_stream(560);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d drive vectors,", bytes_sent, ball_count);
    $display("%0d no-ball and %0d bad-frame results.", no_ball_count, bad_frame_count);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== ball_direction_frame_decoder.f =====
+incdir+hw/rtl
hw/rtl/bdfd_pkg.sv
hw/rtl/bdfd_frame_store.sv
hw/rtl/bdfd_vector_pipe.sv
hw/rtl/ball_direction_frame_decoder.sv
tb/tb_ball_direction_frame_decoder.sv
